/* rtl/splitmix64_uniform_below_macros.svh */
// Assertion macros used by the checker file.
`ifndef SPLITMIX64_UNIFORM_BELOW_MACROS_SVH
`define SPLITMIX64_UNIFORM_BELOW_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SMUB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// A stalled transfer keeps its valid and payload on the next edge, outside reset.
`define SMUB_ASSERT_HOLD(label, clk, rst, vld, stl, data, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && (stl)) |=> ((vld) && $stable(data))) else $error(msg);
`endif

/* rtl/smub_pkg.sv */
// ----------------------------------------------------------------------------
// smub_pkg
// Types and constants for the SplitMix64 bounded-draw block.
// ----------------------------------------------------------------------------
package smub_pkg;

  localparam logic [63:0] GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL2  = 64'h94d049bb133111eb;
  localparam int SH1 = 30;
  localparam int SH2 = 27;
  localparam int SH3 = 31;

  localparam logic CMD_RAW     = 1'b0;
  localparam logic CMD_UNIFORM = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] bound;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        bad_bound;
    logic [31:0] draws_taken;
    logic [63:0] current_state;
  } out_item_t;

  // Handshake between sequencer and shared 64x64 multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  // Handshake between sequencer and shared restoring divider (remainder only).
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

/* rtl/smub_mul.sv */
// ----------------------------------------------------------------------------
// smub_mul
// Low 64 bits of a 64x64 product, one 16x64 partial product per cycle.
// ----------------------------------------------------------------------------
module smub_mul (
  input  logic              clk,
  input  logic              rst,
  input  smub_pkg::mul_req_t req,
  output smub_pkg::mul_rsp_t rsp
);

  logic        busy;
  logic [1:0]  step;
  logic [63:0] acc;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] part;

  // 16 bits of b times a, truncated to the product width
  always_comb begin
    part = a * {48'd0, b[15:0]};
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= 2'd0;
      acc  <= 64'd0;
      a    <= req.a;
      b    <= req.b;
    end else if (busy) begin
      // accumulate and advance to the next digit of b
      acc  <= acc + part;
      a    <= a << 16;
      b    <= b >> 16;
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy     <= 1'b0;
        rsp.done <= 1'b1;
        rsp.prod <= acc + part;
      end
    end
  end

endmodule

/* rtl/smub_div.sv */
// ----------------------------------------------------------------------------
// smub_div
// Restoring remainder of a 64-bit value by a nonzero 64-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smub_div (
  input  logic              clk,
  input  logic              rst,
  input  smub_pkg::div_req_t req,
  output smub_pkg::div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] num;
  logic [63:0] den;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    shifted = {rem, num[63]};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'd0;
      rem  <= 64'd0;
      num  <= req.num;
      den  <= req.den;
    end else if (busy) begin
      // shift in one numerator bit, subtract when it fits
      num <= num << 1;
      cnt <= cnt + 6'd1;
      if (!diff[64]) rem <= diff[63:0];
      else           rem <= shifted[63:0];
      if (cnt == 6'd63) begin
        busy     <= 1'b0;
        rsp.done <= 1'b1;
        rsp.rem  <= diff[64] ? shifted[63:0] : diff[63:0];
      end
    end
  end

endmodule

/* rtl/splitmix64_uniform_below.sv */
// A request on a bound of zero is answered from the idle state without a draw.
// A raw draw advances the state, then runs two multiplies on the shared
// multiplier. A bounded draw first computes its rejection prefix on the
// divider, takes raw draws until one is not below it, then reduces that draw
// on the divider. The remainder divider works in 64 steps and the multiplier
// in 4 steps; one request is worked at a time and in_stall is high meanwhile.
// The result sits in an output register, and a new request is taken from the
// cycle after it is transferred.
// ----------------------------------------------------------------------------
// splitmix64_uniform_below
// SplitMix64 generator with raw and unbiased bounded draws.
// ----------------------------------------------------------------------------
module splitmix64_uniform_below (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seed_we,
  input  logic [63:0]           seed_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  smub_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output smub_pkg::out_item_t   out_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREFIX = 3'd1;
  localparam logic [2:0] S_MUL1   = 3'd2;
  localparam logic [2:0] S_MUL2   = 3'd3;
  localparam logic [2:0] S_REDUCE = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]  state;
  logic [63:0] gen_state;
  logic [31:0] draw_total;
  logic        cmd;
  logic [63:0] bound;
  logic [63:0] prefix;

  smub_pkg::mul_req_t mreq;
  smub_pkg::mul_rsp_t mrsp;
  smub_pkg::div_req_t dreq;
  smub_pkg::div_rsp_t drsp;

  smub_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  smub_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_stall  = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    mreq.start <= 1'b0;
    dreq.start <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      gen_state  <= 64'd0;
      draw_total <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      // drop the result once transferred
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (seed_we) begin
        gen_state  <= seed_data;
        draw_total <= 32'd0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd   <= in_data.command;
            bound <= in_data.bound;
            if (in_data.command == smub_pkg::CMD_UNIFORM && in_data.bound == 64'd0) begin
              out_valid              <= 1'b1;
              out_data.value         <= 64'd0;
              out_data.bad_bound     <= 1'b1;
              out_data.draws_taken   <= draw_total;
              out_data.current_state <= gen_state;
            end else if (in_data.command == smub_pkg::CMD_UNIFORM) begin
              // prefix = (2^64 - bound) mod bound
              dreq.start <= 1'b1;
              dreq.num   <= 64'd0 - in_data.bound;
              dreq.den   <= in_data.bound;
              state      <= S_PREFIX;
            end else begin
              prefix <= 64'd0;
              state  <= S_OUT;
            end
          end
        end
        S_PREFIX: begin
          if (drsp.done) begin
            prefix <= drsp.rem;
            state  <= S_OUT;
          end
        end
        S_MUL1: begin
          if (mrsp.done) begin
            mreq.start <= 1'b1;
            mreq.a     <= mrsp.prod ^ (mrsp.prod >> smub_pkg::SH2);
            mreq.b     <= smub_pkg::MUL2;
            state      <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mrsp.done) begin
            if (cmd == smub_pkg::CMD_RAW) begin
              out_valid              <= 1'b1;
              out_data.value         <= mrsp.prod ^ (mrsp.prod >> smub_pkg::SH3);
              out_data.bad_bound     <= 1'b0;
              out_data.draws_taken   <= draw_total;
              out_data.current_state <= gen_state;
              state                  <= S_IDLE;
            end else if ((mrsp.prod ^ (mrsp.prod >> smub_pkg::SH3)) < prefix) begin
              state <= S_OUT;
            end else begin
              dreq.start <= 1'b1;
              dreq.num   <= mrsp.prod ^ (mrsp.prod >> smub_pkg::SH3);
              dreq.den   <= bound;
              state      <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (drsp.done) begin
            out_valid              <= 1'b1;
            out_data.value         <= drsp.rem;
            out_data.bad_bound     <= 1'b0;
            out_data.draws_taken   <= draw_total;
            out_data.current_state <= gen_state;
            state                  <= S_IDLE;
          end
        end
        S_OUT: begin
          // advance the state and start the avalanche of a new draw
          gen_state  <= gen_state + smub_pkg::GAMMA;
          if (draw_total != 32'hFFFF_FFFF) draw_total <= draw_total + 32'd1;
          mreq.start <= 1'b1;
          mreq.a     <= (gen_state + smub_pkg::GAMMA)
                        ^ ((gen_state + smub_pkg::GAMMA) >> smub_pkg::SH1);
          mreq.b     <= smub_pkg::MUL1;
          state      <= S_MUL1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/smub_checker.sv */
// ----------------------------------------------------------------------------
// smub_checker
// Port-level checks of the SplitMix64 block.
// ----------------------------------------------------------------------------
`include "splitmix64_uniform_below_macros.svh"
module smub_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input smub_pkg::out_item_t out_data
);

  // one request at a time: no transfer while a result waits
  `SMUB_ASSERT_IMP(a_no_in_busy, clk, rst, out_valid, in_stall, "input taken with result pending")
  // a flagged bad bound carries a zero value
  `SMUB_ASSERT_IMP(a_bad, clk, rst, out_valid && out_data.bad_bound, ~|out_data.value, "bad value")
  // stalled result holds
  `SMUB_ASSERT_HOLD(a_hold, clk, rst, out_valid, out_stall, out_data, "held result moved")

endmodule

bind splitmix64_uniform_below smub_checker u_smub_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

/* tb/splitmix64_uniform_below_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitmix64_uniform_below_tb
// Drives raw and bounded draw requests with random idle bursts, predicts each
// result from a local SplitMix64 generator and compares field by field.
// ----------------------------------------------------------------------------
module splitmix64_uniform_below_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int CALM_ITEMS  = 200;

  logic                clk;
  logic                rst;
  logic                seed_we;
  logic [63:0]         seed_data;
  logic                in_valid = 1'b0;
  logic                in_stall;
  smub_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  smub_pkg::out_item_t out_data;

  // Model of the generator.
  logic [63:0] gen_state  = '0;
  logic [31:0] draw_total = '0;

  smub_pkg::in_item_t  request_q[$];
  smub_pkg::out_item_t draw_expect_q[$];
  int        errors  = 0;
  int        cycles  = 0;
  int        in_gap  = 0;
  int        out_gap = 0;
  bit        calm    = 1'b0;
  logic      in_fire = 1'b0;

  splitmix64_uniform_below dut (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed_data(seed_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the model state and return one avalanched draw.
  function automatic logic [63:0] next_draw();
    logic [63:0] z;
    gen_state = gen_state + smub_pkg::GAMMA;
    z = gen_state;
    z = (z ^ (z >> smub_pkg::SH1)) * smub_pkg::MUL1;
    z = (z ^ (z >> smub_pkg::SH2)) * smub_pkg::MUL2;
    if (draw_total != 32'hFFFF_FFFF) draw_total = draw_total + 32'd1;
    return z ^ (z >> smub_pkg::SH3);
  endfunction

  function automatic smub_pkg::out_item_t predict_draw(smub_pkg::in_item_t req);
    smub_pkg::out_item_t res;
    logic [63:0] prefix;
    logic [63:0] d;
    res = '0;
    if (req.command == smub_pkg::CMD_RAW) begin
      res.value = next_draw();
    end else if (req.bound == 64'd0) begin
      res.bad_bound = 1'b1;
    end else begin
      prefix = (64'd0 - req.bound) % req.bound;
      d = next_draw();
      while (d < prefix) d = next_draw();
      res.value = d % req.bound;
    end
    res.draws_taken   = draw_total;
    res.current_state = gen_state;
    return res;
  endfunction

  // Driver: present queued requests, idle in short bursts.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      void'(request_q.pop_front());
      if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
      if (request_q.size() > 0 && in_gap == 0) begin
        in_data <= request_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 1) in_gap = in_gap - 1;
      else if (request_q.size() > 0) begin
        in_gap   = 0;
        in_data  <= request_q[0];
        in_valid <= 1'b1;
      end
    end
  end

  // Hold off the result side in random bursts.
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    smub_pkg::out_item_t want;
    cycles  <= cycles + 1;
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (seed_we) begin
        gen_state  = seed_data;
        draw_total = '0;
      end
      if (in_valid && !in_stall) draw_expect_q.push_back(predict_draw(in_data));
      if (out_valid && !out_stall) begin
        if (draw_expect_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          want = draw_expect_q.pop_front();
          if (want.value !== out_data.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value,
                     out_data.value);
            errors++;
          end
          if (want.bad_bound !== out_data.bad_bound) begin
            $display("%0t: bad_bound expected %b actual %b", $time,
                     want.bad_bound, out_data.bad_bound);
            errors++;
          end
          if (want.draws_taken !== out_data.draws_taken) begin
            $display("%0t: draws_taken expected %h actual %h", $time,
                     want.draws_taken, out_data.draws_taken);
            errors++;
          end
          if (want.current_state !== out_data.current_state) begin
            $display("%0t: current_state expected %h actual %h", $time,
                     want.current_state, out_data.current_state);
            errors++;
          end
        end
      end
    end
  end

  // Timeout.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Bounds of varied magnitude, so prefixes and reductions span all sizes.
  function automatic logic [63:0] rand_bound();
    logic [63:0] b;
    int          sh;
    sh = $urandom_range(0, 63);
    b = rand64() >> sh;
    case ($urandom_range(0, 9))
      0: b = 64'd1;
      1: b = 64'h8000_0000_0000_0001 + (rand64() >> 2);
      2: b = 64'd0;
      default: ;
    endcase
    return b;
  endfunction

  function automatic smub_pkg::in_item_t make_req(logic cmd, logic [63:0] b);
    smub_pkg::in_item_t r;
    r.command = cmd;
    r.bound   = b;
    return r;
  endfunction

  // Let queued requests finish, then load a new seed while idle.
  task automatic reseed(logic [63:0] s);
    while (request_q.size() > 0 || draw_expect_q.size() > 0 || in_valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
    seed_we   <= 1'b1;
    seed_data <= s;
    @(negedge clk);
    seed_we <= 1'b0;
  endtask

  initial begin
    logic [63:0] seeds[4];
    rst        = 1'b1;
    seed_we    = 1'b0;
    seed_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset seed, raw draws, zero / one / extreme bounds.
    request_q.push_back(make_req(smub_pkg::CMD_RAW, 64'd0));
    request_q.push_back(make_req(smub_pkg::CMD_RAW, 64'hFFFF_FFFF_FFFF_FFFF));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'd0));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'd1));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'd2));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'd3));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'hFFFF_FFFF_FFFF_FFFF));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'h8000_0000_0000_0000));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'h8000_0000_0000_0001));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'hC000_0000_0000_0001));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'd0));
    request_q.push_back(make_req(smub_pkg::CMD_RAW, 64'd5));

    // Extreme seeds, then random ones.
    seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[1] = 64'd0;
    seeds[2] = rand64();
    seeds[3] = rand64();
    reseed(seeds[0]);
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'hAAAA_AAAA_AAAA_AAAB));
    request_q.push_back(make_req(smub_pkg::CMD_RAW, 64'd0));
    request_q.push_back(make_req(smub_pkg::CMD_UNIFORM, 64'd7));

    for (int phase = 0; phase < 4; phase++) begin
      reseed(seeds[phase]);
      for (int i = 0; i < 420; i++)
        request_q.push_back(make_req(1'($urandom_range(0, 1)), rand_bound()));
    end

    // Final stretch with no idling.
    while (request_q.size() > CALM_ITEMS) @(posedge clk);
    calm = 1;
    while (request_q.size() > 0 || draw_expect_q.size() > 0 || in_valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
